// ===== src/wcd_pkg.sv =====
// Package for the windowed convergence detector.
// Holds the controller states, the command and status bundles and fixed constants.
// No dependencies.
`timescale 1ns / 1ps

package wcd_pkg;

  localparam int WW_BITS      = 9;
  localparam int THR_BITS     = 16;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_INDEX_W  = 1;
  localparam int IN_W         = 32;
  localparam int MEAN_W       = 32;
  localparam int OUT_W        = 40;
  localparam int REL_SHIFT    = 17;

  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_WIDTH     = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_CHANGE_THRESHOLD = 1'b1;

  localparam logic [WW_BITS-1:0]  WIDTH_RESET  = 9'd5;
  localparam logic [THR_BITS-1:0] THRESH_RESET = 16'd3277;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ_MID,
    S_READ_OLD,
    S_UPDATE,
    S_PREP,
    S_ITER,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic rd_mid;
    logic rd_old;
    logic update;
    logic prep;
    logic step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic iter_last;
    logic out_free;
  } sts_t;

endpackage

// ===== src/windowed_convergence_detector.sv =====
// Top level of the windowed convergence detector.
// Depends on wcd_pkg, wcd_ctrl and wcd_datapath.
//
// Each input transfer on the s_ group carries one unsigned Q16.16 sample. The
// block keeps the last 2W samples in a ring memory with running sums of the
// newest W samples and of the W samples before them, and gives one result
// transfer on the m_ group for every sample.
// A window comparison is made when at least 2W samples have arrived and the
// count of earlier samples is a multiple of W; the result then says whether
// the relative change of the two window means is below the threshold. Once the
// ring is full every result also carries the newest window mean.
// An item passes through the states S_READ_MID, S_READ_OLD, S_UPDATE, S_PREP,
// S_ITER and S_EMIT between its input transfer and a valid result. The serial
// divider that forms the mean runs alongside the serial threshold multiplier
// in S_ITER, and a new sample is taken only in S_IDLE, once the result of the
// previous sample has been placed in the output register.
// One sample is accepted while a result waits in the output register; a longer
// stall holds the following result back and the input with it.
// Reset restores the default window width and threshold and empties the
// detector. Writing the window width also empties the detector.
`timescale 1ns / 1ps

module windowed_convergence_detector #(
  parameter int MAX_WINDOW  = 256,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [wcd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [wcd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // sample_value [31:0]
  input  logic [wcd_pkg::IN_W-1:0]        s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // converged [0], check_done [1], mean_valid [2], current_mean [34:3], zero [39:35]
  output logic [wcd_pkg::OUT_W-1:0]       m_tdata
);

  wcd_pkg::cmd_t cmd;
  wcd_pkg::sts_t sts;

  wcd_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  wcd_datapath #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

// ===== src/wcd_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module wcd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/wcd_ctrl.sv =====
// Controller state machine of the windowed convergence detector.
// Depends on wcd_pkg for the state type and the command and status bundles.
`timescale 1ns / 1ps

module wcd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  wcd_pkg::sts_t sts,
  output wcd_pkg::cmd_t cmd
);

  wcd_pkg::state_t state;
  wcd_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wcd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      wcd_pkg::S_IDLE: begin
        if (s_tvalid) begin
          state_next = wcd_pkg::S_READ_MID;
        end
      end
      wcd_pkg::S_READ_MID: state_next = wcd_pkg::S_READ_OLD;
      wcd_pkg::S_READ_OLD: state_next = wcd_pkg::S_UPDATE;
      wcd_pkg::S_UPDATE:   state_next = wcd_pkg::S_PREP;
      wcd_pkg::S_PREP:     state_next = wcd_pkg::S_ITER;
      wcd_pkg::S_ITER: begin
        if (sts.iter_last) begin
          state_next = wcd_pkg::S_EMIT;
        end
      end
      wcd_pkg::S_EMIT: begin
        if (sts.out_free) begin
          state_next = wcd_pkg::S_IDLE;
        end
      end
      default: state_next = wcd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      wcd_pkg::S_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      wcd_pkg::S_READ_MID: cmd.rd_mid = 1'b1;
      wcd_pkg::S_READ_OLD: cmd.rd_old = 1'b1;
      wcd_pkg::S_UPDATE:   cmd.update = 1'b1;
      wcd_pkg::S_PREP:     cmd.prep   = 1'b1;
      wcd_pkg::S_ITER:     cmd.step   = 1'b1;
      wcd_pkg::S_EMIT:     cmd.emit   = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== src/wcd_datapath.sv =====
// Datapath of the windowed convergence detector: sample ring, window sums,
// serial multiplier and divider, configuration registers and output register.
// Depends on wcd_pkg and wcd_ram.
`timescale 1ns / 1ps

module wcd_datapath #(
  parameter int MAX_WINDOW  = 256,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [wcd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [wcd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [wcd_pkg::IN_W-1:0]           s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [wcd_pkg::OUT_W-1:0]          m_tdata,
  input  wcd_pkg::cmd_t                      cmd,
  output wcd_pkg::sts_t                      sts
);

  localparam int WB     = $clog2(MAX_WINDOW + 1);
  localparam int RB     = WB + 1;
  localparam int DEPTH  = 2 * MAX_WINDOW;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XB     = (SAMPLE_BITS < wcd_pkg::IN_W) ? SAMPLE_BITS : wcd_pkg::IN_W;
  localparam int SUM_W  = SAMPLE_BITS + WB;
  localparam int CMP_W  = SUM_W + 1 + wcd_pkg::THR_BITS;
  localparam int ITERS  = (SUM_W > wcd_pkg::THR_BITS) ? SUM_W : wcd_pkg::THR_BITS;
  localparam int CNT_W  = $clog2(ITERS);

  logic [wcd_pkg::WW_BITS-1:0]  ww;
  logic [wcd_pkg::THR_BITS-1:0] thr;
  logic [WB-1:0]                w_eff;
  logic [RB-1:0]                r_len;

  logic [AW-1:0]          ptr;
  logic [RB-1:0]          fill;
  logic [WB-1:0]          phase;
  logic [SUM_W-1:0]       newer_sum;
  logic [SUM_W-1:0]       older_sum;

  logic [SAMPLE_BITS-1:0] x_reg;
  logic [SAMPLE_BITS-1:0] mid_reg;
  logic                   full_f;
  logic                   check_f;

  logic [SUM_W-1:0]       diff;
  logic [CMP_W-1:0]       mcand;
  logic [wcd_pkg::THR_BITS-1:0] mplier;
  logic [CMP_W-1:0]       prod;
  logic [WB-1:0]          div_rem;
  logic [SUM_W-1:0]       div_q;
  logic [CNT_W-1:0]       cnt;

  logic [SAMPLE_BITS-1:0] ram_rdata;
  logic [AW-1:0]          ram_raddr;
  logic [AW:0]            mid_sum;
  logic [AW-1:0]          mid_idx;
  logic [AW:0]            ptr_inc;
  logic [RB-1:0]          fill_inc;
  logic [WB:0]            phase_inc;
  logic [SAMPLE_BITS-1:0] oldest_v;
  logic [SUM_W-1:0]       newer_next;
  logic [SUM_W-1:0]       older_next;
  logic [SUM_W:0]         ab_sum;
  logic [WB:0]            rem_sh;
  logic                   q_bit;
  logic                   div_en;
  logic [CMP_W-1:0]       lhs;
  logic                   conv;
  logic                   wr_width;

  always_comb begin
    if (ww == '0) begin
      w_eff = WB'(1);
    end else if (32'(ww) > 32'(MAX_WINDOW)) begin
      w_eff = WB'(MAX_WINDOW);
    end else begin
      w_eff = WB'(ww);
    end
  end

  assign r_len = {w_eff, 1'b0};

  assign mid_sum   = (AW + 1)'(ptr) + (AW + 1)'(w_eff);
  assign mid_idx   = (mid_sum >= (AW + 1)'(r_len)) ? AW'(mid_sum - (AW + 1)'(r_len))
                                                   : AW'(mid_sum);
  assign ram_raddr = cmd.rd_old ? ptr : mid_idx;

  assign ptr_inc   = (AW + 1)'(ptr) + (AW + 1)'(1);
  assign fill_inc  = (fill < r_len) ? fill + RB'(1) : fill;
  assign phase_inc = (WB + 1)'(phase) + (WB + 1)'(1);

  assign oldest_v   = (fill >= r_len) ? ram_rdata : '0;
  assign newer_next = newer_sum + SUM_W'(x_reg) - SUM_W'(mid_reg);
  assign older_next = older_sum + SUM_W'(mid_reg) - SUM_W'(oldest_v);

  assign ab_sum = (SUM_W + 1)'(newer_sum) + (SUM_W + 1)'(older_sum);

  assign rem_sh = {div_rem, div_q[SUM_W-1]};
  assign q_bit  = (rem_sh >= (WB + 1)'(w_eff));
  assign div_en = ({1'b0, cnt} < (CNT_W + 1)'(SUM_W));

  assign lhs  = CMP_W'(diff) << wcd_pkg::REL_SHIFT;
  assign conv = check_f && (lhs < prod);

  assign wr_width = cfg_we && (cfg_index == wcd_pkg::REG_WINDOW_WIDTH);

  assign sts.iter_last = (cnt == CNT_W'(ITERS - 1));
  assign sts.out_free  = !m_tvalid || m_tready;

  wcd_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (cmd.update),
    .waddr(ptr),
    .wdata(x_reg),
    .re   (cmd.rd_mid || cmd.rd_old),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ww        <= wcd_pkg::WIDTH_RESET;
      thr       <= wcd_pkg::THRESH_RESET;
      ptr       <= '0;
      fill      <= '0;
      phase     <= '0;
      newer_sum <= '0;
      older_sum <= '0;
    end else begin
      if (cmd.update) begin
        newer_sum <= newer_next;
        older_sum <= older_next;
        ptr       <= (ptr_inc >= (AW + 1)'(r_len)) ? '0 : AW'(ptr_inc);
        fill      <= fill_inc;
        phase     <= (phase_inc >= (WB + 1)'(w_eff)) ? '0 : WB'(phase_inc);
      end
      if (cfg_we && (cfg_index == wcd_pkg::REG_CHANGE_THRESHOLD)) begin
        thr <= cfg_data[wcd_pkg::THR_BITS-1:0];
      end
      if (wr_width) begin
        ww        <= cfg_data[wcd_pkg::WW_BITS-1:0];
        ptr       <= '0;
        fill      <= '0;
        phase     <= '0;
        newer_sum <= '0;
        older_sum <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_reg <= SAMPLE_BITS'(s_tdata[XB-1:0]);
    end
    if (cmd.rd_old) begin
      mid_reg <= (fill >= RB'(w_eff)) ? ram_rdata : '0;
    end
    if (cmd.update) begin
      full_f  <= (fill_inc >= r_len);
      check_f <= (fill_inc >= r_len) && (phase == '0);
    end
    if (cmd.prep) begin
      diff    <= (newer_sum >= older_sum) ? newer_sum - older_sum : older_sum - newer_sum;
      mcand   <= CMP_W'(ab_sum);
      mplier  <= thr;
      prod    <= '0;
      div_q   <= newer_sum;
      div_rem <= '0;
      cnt     <= '0;
    end
    if (cmd.step) begin
      cnt    <= cnt + CNT_W'(1);
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
      if (mplier[0]) begin
        prod <= prod + mcand;
      end
      if (div_en) begin
        div_rem <= q_bit ? WB'(rem_sh - (WB + 1)'(w_eff)) : WB'(rem_sh);
        div_q   <= {div_q[SUM_W-2:0], q_bit};
      end
    end
    if (cmd.emit) begin
      m_tdata <= {5'b0,
                  full_f ? wcd_pkg::MEAN_W'(div_q) : {wcd_pkg::MEAN_W{1'b0}},
                  full_f, check_f, conv};
    end
  end

endmodule
